// ===== hdl/mpd_pkg.sv =====
// Shared types, constants and the letter lookup for the Morse pulse decoder.
package mpd_pkg;

   // Timer and symbol buffer sizing
   localparam int TIMER_BITS  = 16;
   localparam int MAX_SYMBOLS = 5;
   localparam int OVF_BITS    = 16;
   localparam int LEN_BITS    = 32;
   localparam int SYM_W       = MAX_SYMBOLS;
   localparam int CNT_W       = $clog2(MAX_SYMBOLS + 2);
   localparam int NUM_LETTERS = 26;
   localparam int LETTER_W    = 5;
   localparam int CSR_IDX_W   = 2;

   localparam logic [OVF_BITS-1:0] OVF_MAX     = '1;
   localparam logic [CNT_W-1:0]    CNT_FULL    = CNT_W'(MAX_SYMBOLS);
   localparam logic [CNT_W-1:0]    CNT_TOOLONG = CNT_W'(MAX_SYMBOLS + 1);

   // Reset values of the thresholds
   localparam logic [LEN_BITS-1:0] DOT_MIN_RST   = LEN_BITS'(1966);
   localparam logic [LEN_BITS-1:0] DASH_MIN_RST  = LEN_BITS'(13100);
   localparam logic [LEN_BITS-1:0] SPACE_MIN_RST = LEN_BITS'(26000);

   // Event codes on the request side
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_EDGE = 1'b1;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOT_MIN   = 2'd0,
      CSR_DASH_MIN  = 2'd1,
      CSR_SPACE_MIN = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_idx_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_DOT      = 2'd1,
      KIND_DASH     = 2'd2,
      KIND_BOUNDARY = 2'd3
   } kind_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] dot_min;
      logic [LEN_BITS-1:0] dash_min;
      logic [LEN_BITS-1:0] space_min;
   } thresholds_type;

   typedef struct packed {
      logic                hit;
      logic [LETTER_W-1:0] idx;
   } letter_hit_type;

   // Morse codes of A..Z: length, and symbol i in bit i (1 = dash)
   localparam int LetterLen [NUM_LETTERS] = '{
      2, 4, 4, 3, 1, 4, 3, 4, 2, 4, 3, 4, 2,
      2, 3, 4, 4, 3, 3, 1, 3, 4, 3, 4, 4, 4
   };
   localparam int LetterBits [NUM_LETTERS] = '{
      2, 1, 5, 1, 0, 4, 3, 0, 0, 14, 5, 2, 3,
      1, 7, 6, 11, 2, 0, 1, 4, 8, 6, 9, 13, 3
   };

   // Match the buffered code against the alphabet; lowest letter wins
   function automatic letter_hit_type lookup_letter(input logic [SYM_W-1:0] bits,
                                                    input logic [CNT_W-1:0] count);
      letter_hit_type res;
      res = '0;
      for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
         if (count == CNT_W'(LetterLen[i]) && bits == SYM_W'(LetterBits[i])) begin
            res.hit = 1'b1;
            res.idx = LETTER_W'(i);
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/morse_pulse_decoder.sv =====
// Morse pulse decoder top level: input stage, decode step, result register.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid / req_tready | tdata: capture_time, tuser: op
//   rsp     | out       | rsp_tvalid / rsp_tready | tdata: letter_valid, letter_index;
//           |           |                         | tuser: symbol_kind
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// One beat per cycle sustained while rsp is not stalled; a request beat goes into the input
// register, then through the decode step into the result register, from which it leaves on rsp.
// The decode step is one 32-bit subtract-and-add feeding the threshold compares; the
// letter match works on the buffered symbols.
// Reset (synchronous) empties both stages, clears the decoder state and reloads the
// default thresholds.
// A stalled rsp holds the result; the input stage takes one more beat, then req_tready drops.
module morse_pulse_decoder
   import mpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TIMER_BITS-1:0] req_tdata,   // [15:0] capture_time
   input  logic                  req_tuser,   // [0] op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] letter_valid, [5:1] letter_index, pad
   output logic [1:0]            rsp_tuser,   // [1:0] symbol_kind
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [LEN_BITS-1:0]   csr_data
);

   thresholds_type thr;

   mpd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .thresholds (thr)
   );

   // Input stage
   logic                  in_valid_ff, in_valid_in;
   logic                  in_op_ff;
   logic [TIMER_BITS-1:0] in_cap_ff;

   // Decoder state
   logic [TIMER_BITS-1:0] last_edge_ff, last_edge_in;
   logic [OVF_BITS-1:0]   ovf_ff, ovf_in;
   logic [LEN_BITS-1:0]   mark_len_ff, mark_len_in;
   logic [LEN_BITS-1:0]   gap_len_ff, gap_len_in;
   logic                  level_ff, level_in;
   logic [SYM_W-1:0]      sym_bits_ff, sym_bits_in;
   logic [CNT_W-1:0]      sym_cnt_ff, sym_cnt_in;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic                  rsp_lv_ff, rsp_lv_in;
   logic [LETTER_W-1:0]   rsp_idx_ff, rsp_idx_in;

   logic                  advance;
   logic [LEN_BITS-1:0]   span;
   logic [LEN_BITS-1:0]   gap_eff;
   logic                  is_dot, is_dash, is_gap;
   letter_hit_type        hit;

   // Item moves from input stage into result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {2'b00, rsp_idx_ff, rsp_lv_ff};

   // Elapsed time since the last edge, modulo 2^32
   assign span = LEN_BITS'(in_cap_ff) - LEN_BITS'(last_edge_ff)
               + LEN_BITS'({ovf_ff, {TIMER_BITS{1'b0}}});

   assign gap_eff = level_ff ? gap_len_ff : span;
   assign is_dot  = level_ff && (thr.dot_min <= span) && (span < thr.dash_min);
   assign is_dash = level_ff && (thr.dash_min <= span);
   assign is_gap  = thr.space_min <= gap_eff;
   assign hit     = lookup_letter(sym_bits_ff, sym_cnt_ff);

   // Input stage load
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance)             in_valid_in = 1'b0;
   end

   // Decode step
   always_comb begin
      last_edge_in = last_edge_ff;
      ovf_in       = ovf_ff;
      mark_len_in  = mark_len_ff;
      gap_len_in   = gap_len_ff;
      level_in     = level_ff;
      sym_bits_in  = sym_bits_ff;
      sym_cnt_in   = sym_cnt_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_lv_in    = rsp_lv_ff;
      rsp_idx_in   = rsp_idx_ff;
      if (advance) begin
         rsp_kind_in = KIND_NONE;
         rsp_lv_in   = 1'b0;
         rsp_idx_in  = '0;
         if (in_op_ff == OP_TICK) begin
            if (ovf_ff != OVF_MAX) ovf_in = ovf_ff + OVF_BITS'(1);
         end else begin
            if (level_ff) mark_len_in = span;
            else          gap_len_in  = span;
            last_edge_in = in_cap_ff;
            ovf_in       = '0;
            level_in     = !level_ff;
            if (is_dot || is_dash) begin
               rsp_kind_in = is_dot ? KIND_DOT : KIND_DASH;
               if (sym_cnt_ff < CNT_FULL) begin
                  sym_bits_in = sym_bits_ff | (SYM_W'(is_dash && !is_dot) << sym_cnt_ff);
                  sym_cnt_in  = sym_cnt_ff + CNT_W'(1);
               end else begin
                  sym_cnt_in  = CNT_TOOLONG;
               end
            end else if (is_gap) begin
               rsp_kind_in = KIND_BOUNDARY;
               rsp_lv_in   = hit.hit;
               rsp_idx_in  = hit.idx;
               sym_bits_in = '0;
               sym_cnt_in  = '0;
            end
         end
      end
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // Control and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_edge_ff <= '0;
         ovf_ff       <= '0;
         mark_len_ff  <= '0;
         gap_len_ff   <= '0;
         level_ff     <= 1'b0;
         sym_bits_ff  <= '0;
         sym_cnt_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_edge_ff <= last_edge_in;
         ovf_ff       <= ovf_in;
         mark_len_ff  <= mark_len_in;
         gap_len_ff   <= gap_len_in;
         level_ff     <= level_in;
         sym_bits_ff  <= sym_bits_in;
         sym_cnt_ff   <= sym_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff  <= req_tuser;
         in_cap_ff <= req_tdata;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_lv_ff   <= rsp_lv_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

endmodule

// ===== hdl/mpd_csr.sv =====
// Threshold register file written through the csr channel.
module mpd_csr
   import mpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_BITS-1:0]  csr_data,
   output thresholds_type       thresholds
);

   thresholds_type thr_ff, thr_in;

   assign csr_ready  = 1'b1;
   assign thresholds = thr_ff;

   // Write decode; an unused index is dropped
   always_comb begin
      thr_in = thr_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_DOT_MIN:   thr_in.dot_min   = csr_data;
            CSR_DASH_MIN:  thr_in.dash_min  = csr_data;
            CSR_SPACE_MIN: thr_in.space_min = csr_data;
            default:       thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.dot_min   <= DOT_MIN_RST;
         thr_ff.dash_min  <= DASH_MIN_RST;
         thr_ff.space_min <= SPACE_MIN_RST;
      end else begin
         thr_ff <= thr_in;
      end
   end

endmodule

// ===== hdl/mpd_checker.sv =====
// Port-level checks for the Morse pulse decoder, bound to the top level.
module mpd_checker
   import mpd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [7:0]            rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // A stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // A stalled result beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // A decoded letter only comes with a letter boundary
   a_letter_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser == KIND_BOUNDARY)
      else $error("letter reported outside a boundary");

   // Letter index is in A..Z when valid and zero otherwise
   a_letter_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] ? (rsp_tdata[5:1] <= 5'd25) : (rsp_tdata[5:1] == 5'd0)))
      else $error("letter index out of range");

endmodule

bind morse_pulse_decoder mpd_checker u_mpd_checker (.*);
